// File: rtl/assert_macros.svh
// Assertion shorthands, clocked on the rising edge of clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_SYNC(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/csq_pkg.sv
package csq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_BITS     = 8;
   localparam int FIELD_ID_BITS = 8;
   localparam int TOTAL_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam logic signed [15:0] COUNT_MIN = 16'sh8000;
   localparam logic signed [15:0] COUNT_MAX = 16'sh7FFF;

   typedef enum logic [1:0] {
      OP_WAIT   = 2'd0,
      OP_SIGNAL = 2'd1,
      OP_REMOVE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_PROCEED  = 4'd0,
      ST_BLOCKED  = 4'd1,
      ST_REFUSED  = 4'd2,
      ST_WOKE     = 4'd3,
      ST_NONE     = 4'd4,
      ST_REMOVED  = 4'd5,
      ST_NOTFOUND = 4'd6,
      ST_FULL     = 4'd7,
      ST_READ     = 4'd8
   } status_type;

   typedef struct packed {
      logic capture;   // request transfer taken this edge
      logic execute;   // apply op, load response registers
   } ctrl_cmd_type;

   typedef struct packed {
      logic [TOTAL_BITS-1:0] total;
   } dp_stat_type;

   // Low ID_BITS of the id field, zero filled above the field.
   function automatic logic [ID_BITS-1:0] id_from_field(input logic [FIELD_ID_BITS-1:0] f);
      logic [ID_BITS-1:0] r;
      for (int i = 0; i < ID_BITS; i++) begin
         r[i] = (i < FIELD_ID_BITS) ? f[(i < FIELD_ID_BITS) ? i : 0] : 1'b0;
      end
      return r;
   endfunction

   function automatic logic [FIELD_ID_BITS-1:0] id_to_field(input logic [ID_BITS-1:0] v);
      logic [FIELD_ID_BITS-1:0] r;
      for (int i = 0; i < FIELD_ID_BITS; i++) begin
         r[i] = (i < ID_BITS) ? v[(i < ID_BITS) ? i : 0] : 1'b0;
      end
      return r;
   endfunction

endpackage

// File: rtl/csq_dp.sv
module csq_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  csq_pkg::ctrl_cmd_type                cmd,
   output csq_pkg::dp_stat_type                 stat,
   input  logic                                 cfg_we,
   input  logic signed [15:0]                   cfg_count,
   output logic signed [15:0]                   init_count,
   input  logic [1:0]                           req_opcode,
   input  logic [csq_pkg::FIELD_ID_BITS-1:0]    req_thread_id,
   input  logic                                 req_may_block,
   output logic [3:0]                           rsp_status,
   output logic [csq_pkg::FIELD_ID_BITS-1:0]    rsp_woken_id,
   output logic signed [15:0]                   rsp_count_now
);

   localparam int DEPTH = csq_pkg::QUEUE_DEPTH;
   localparam int IDW   = csq_pkg::ID_BITS;
   localparam int TW    = csq_pkg::TOTAL_BITS;

   logic signed [15:0] init_ff, init_in;
   logic signed [15:0] count_ff, count_in;
   logic [TW-1:0]      total_ff, total_in;
   logic [IDW-1:0]     queue_ff [DEPTH];
   logic [IDW-1:0]     queue_in [DEPTH];

   // captured item and search result
   csq_pkg::op_type    op_ff, op_in;
   logic [IDW-1:0]     id_ff, id_in;
   logic               blk_ff, blk_in;
   logic [DEPTH-1:0]   match_ff, match_in;

   csq_pkg::status_type status_ff, status_in;
   logic [IDW-1:0]      woken_ff, woken_in;
   logic signed [15:0]  cnow_ff, cnow_in;

   logic [DEPTH-1:0]   after_mask;
   logic               run;
   logic               shift_en, push_en;
   logic [DEPTH-1:0]   shift_mask;
   logic signed [15:0] count_dec, count_inc;

   // parallel compare against every occupied cell
   always_comb begin
      id_in  = csq_pkg::id_from_field(req_thread_id);
      op_in  = csq_pkg::op_type'(req_opcode);
      blk_in = req_may_block;
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = (total_ff > TW'(i)) && (queue_ff[i] == id_in);
      end
   end

   // cells at and after the oldest match move down one
   always_comb begin
      run = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         run           = run | match_ff[i];
         after_mask[i] = run;
      end
   end

   assign count_dec = (count_ff != csq_pkg::COUNT_MIN) ? count_ff - 16'sd1 : count_ff;
   assign count_inc = (count_ff != csq_pkg::COUNT_MAX) ? count_ff + 16'sd1 : count_ff;

   always_comb begin
      count_in   = count_ff;
      total_in   = total_ff;
      status_in  = status_ff;
      woken_in   = woken_ff;
      shift_en   = 1'b0;
      push_en    = 1'b0;
      shift_mask = after_mask;
      if (cmd.execute) begin
         woken_in = '0;
         case (op_ff)
            csq_pkg::OP_WAIT: begin
               if (blk_ff) begin
                  if (count_dec < 16'sd0) begin
                     if (total_ff >= TW'(DEPTH)) begin
                        status_in = csq_pkg::ST_FULL;
                     end else begin
                        push_en   = 1'b1;
                        total_in  = total_ff + TW'(1);
                        count_in  = count_dec;
                        status_in = csq_pkg::ST_BLOCKED;
                     end
                  end else begin
                     count_in  = count_dec;
                     status_in = csq_pkg::ST_PROCEED;
                  end
               end else begin
                  status_in = (count_ff <= 16'sd0) ? csq_pkg::ST_REFUSED
                                                   : csq_pkg::ST_PROCEED;
               end
            end
            csq_pkg::OP_SIGNAL: begin
               count_in  = count_inc;
               status_in = csq_pkg::ST_NONE;
               if ((count_ff < 16'sd0) && (total_ff != '0)) begin
                  woken_in   = queue_ff[0];
                  shift_en   = 1'b1;
                  shift_mask = '1;
                  total_in   = total_ff - TW'(1);
                  status_in  = csq_pkg::ST_WOKE;
               end
            end
            csq_pkg::OP_REMOVE: begin
               if (|match_ff) begin
                  shift_en  = 1'b1;
                  total_in  = total_ff - TW'(1);
                  status_in = csq_pkg::ST_REMOVED;
               end else begin
                  status_in = csq_pkg::ST_NOTFOUND;
               end
            end
            csq_pkg::OP_READ: begin
               status_in = csq_pkg::ST_READ;
            end
            default: begin
               status_in = csq_pkg::ST_READ;
            end
         endcase
      end
      cnow_in = count_in;
      init_in = init_ff;
      if (cfg_we) begin
         init_in  = cfg_count;
         count_in = cfg_count;
         total_in = '0;
         shift_en = 1'b0;
         push_en  = 1'b0;
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         queue_in[i] = queue_ff[i];
         if (shift_en && shift_mask[i]) begin
            queue_in[i] = queue_ff[(i + 1 < DEPTH) ? i + 1 : i];
         end
         if (push_en && (total_ff == TW'(i))) begin
            queue_in[i] = id_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff  <= '0;
         count_ff <= '0;
         total_ff <= '0;
      end else begin
         init_ff  <= init_in;
         count_ff <= count_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
      if (cmd.capture) begin
         op_ff    <= op_in;
         id_ff    <= id_in;
         blk_ff   <= blk_in;
         match_ff <= match_in;
      end
      if (cmd.execute) begin
         status_ff <= status_in;
         woken_ff  <= woken_in;
         cnow_ff   <= cnow_in;
      end
   end

   assign stat.total    = total_ff;
   assign init_count    = init_ff;
   assign rsp_status    = status_ff;
   assign rsp_woken_id  = csq_pkg::id_to_field(woken_ff);
   assign rsp_count_now = cnow_ff;

endmodule

// File: rtl/csq_ctrl.sv
`include "assert_macros.svh"

module csq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output csq_pkg::ctrl_cmd_type cmd,
   input  csq_pkg::dp_stat_type  stat
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.capture  = req_valid && req_ready_ff;
      cmd.execute  = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (cmd.capture) begin
               state_in     = S_EXEC;
               req_ready_in = 1'b0;
            end
         end
         S_EXEC: begin
            if (cmd.execute) begin
               state_in     = S_IDLE;
               req_ready_in = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in     = S_IDLE;
            req_ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == S_IDLE) ? 1'b1 : req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   `ASSERT_SYNC(a_total_bound, stat.total <= csq_pkg::TOTAL_BITS'(csq_pkg::QUEUE_DEPTH), "queue occupancy beyond depth")
   `ASSERT_SYNC(a_no_overwrite, cmd.execute |-> (!rsp_valid_ff || rsp_ready), "response overwritten before transfer")
   `ASSERT_SYNC(a_capture_blocks, cmd.capture |=> (!req_ready_ff && state_ff == S_EXEC), "request taken while busy")
   `ASSERT_ALWAYS(a_reset_quiet, $past(reset) |-> (!rsp_valid_ff && !req_ready_ff), "handshake live after reset")

endmodule

// File: rtl/counting_semaphore_wait_queue_unit.sv
// Counting semaphore with a FIFO wait queue of blocked thread ids.
// Request channel (req_valid/req_ready): opcode, thread_id, may_block.
//   wait (blocking or try), signal, remove waiter, read count.
// Response channel (rsp_valid/rsp_ready): status, woken_id, count_now;
//   exactly one response transfer per request transfer, in order.
// Timing: a request is taken with req_ready high; the op is applied in
//   the execute state once the output register is free, and the
//   response is visible in the cycle after. No new request is taken
//   until the last is applied, when the wait-queue cell chain shifts;
//   the compare of all cells is done at the request transfer edge.
// Stall: a response waiting on rsp_ready does not block the next request
//   transfer; that request holds in its execute cycle until the output
//   register is free.
// Reset (synchronous, active high): count 0, queue empty, initial_count 0.
// APB register 0 (byte address 0): initial_count, 16 bit signed. Writing
//   it reloads the count and empties the queue; write only while idle.
//   Reads return the value sign extended to 32 bits.
module counting_semaphore_wait_queue_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_opcode,
   input  logic [csq_pkg::FIELD_ID_BITS-1:0]    req_thread_id,
   input  logic                                 req_may_block,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [3:0]                           rsp_status,
   output logic [csq_pkg::FIELD_ID_BITS-1:0]    rsp_woken_id,
   output logic signed [15:0]                   rsp_count_now,
   // APB configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [2:0]                           paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   csq_pkg::ctrl_cmd_type cmd;
   csq_pkg::dp_stat_type  stat;
   logic                  cfg_hit;
   logic                  cfg_we;
   logic signed [15:0]    init_count;

   // Single word register; paddr[2] set lies beyond it.
   assign cfg_hit = (paddr[2] == 1'b0);
   assign pready  = 1'b1;
   assign cfg_we  = psel && penable && pwrite && pready && cfg_hit;
   assign prdata  = cfg_hit ? {{16{init_count[15]}}, init_count} : '0;

   // Sequencer: takes request transfers, paces execute and response.
   csq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Count, wait-queue cell chain and response registers.
   csq_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .cfg_we        (cfg_we),
      .cfg_count     (pwdata[15:0]),
      .init_count    (init_count),
      .req_opcode    (req_opcode),
      .req_thread_id (req_thread_id),
      .req_may_block (req_may_block),
      .rsp_status    (rsp_status),
      .rsp_woken_id  (rsp_woken_id),
      .rsp_count_now (rsp_count_now)
   );

endmodule
